// ===== src/ssgc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssgc_pkg
// Types and constants shared by the stable stop goal checker files.
// ----------------------------------------------------------------------------
package ssgc_pkg;

  localparam int PosW   = 32;
  localparam int AngW   = 16;
  localparam int VelW   = 16;
  localparam int TimeW  = 32;
  localparam int TolW   = 31;
  localparam int StopW  = 15;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 3;

  localparam logic MODE_EVAL    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_X_TOL     = 3'd0,
    REG_Y_TOL     = 3'd1,
    REG_YAW_TOL   = 3'd2,
    REG_STOP_SPD  = 3'd3,
    REG_STOP_TURN = 3'd4,
    REG_XY_DWELL  = 3'd5,
    REG_YAW_DWELL = 3'd6,
    REG_STAGED    = 3'd7
  } ssgc_reg_t;

  typedef struct packed {
    logic                   mode;
    logic [TimeW-1:0]       time_ms;
    logic signed [PosW-1:0] query_x;
    logic signed [PosW-1:0] query_y;
    logic [AngW-1:0]        query_yaw;
    logic signed [PosW-1:0] goal_x;
    logic signed [PosW-1:0] goal_y;
    logic [AngW-1:0]        goal_yaw;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] vel_turn;
  } ssgc_in_t;

  typedef struct packed {
    logic goal_reached;
    logic in_yaw_phase;
    logic pose_ok;
  } ssgc_out_t;

endpackage

// ===== src/ssgc_if.sv =====
// ----------------------------------------------------------------------------
// ssgc_in_if / ssgc_out_if
// Valid/ready channels carrying pose items in and goal status items out.
// ----------------------------------------------------------------------------
interface ssgc_in_if;
  import ssgc_pkg::*;
  logic     valid;
  logic     ready;
  ssgc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssgc_out_if;
  import ssgc_pkg::*;
  logic      valid;
  logic      ready;
  ssgc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/stable_stop_goal_checker_unit.sv =====
// ----------------------------------------------------------------------------
// stable_stop_goal_checker_unit
// Goal reached checker with position/yaw tolerances, dwell timers and a
// stop condition on planar speed and turn rate.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | mode, time, pose, goal, velocity
//  out_ch  | out | valid/ready   | goal_reached, in_yaw_phase, pose_ok
//  cfg_*   | in  | write enable  | 3-bit register index, 32-bit data
//
// One item per cycle while the output is not stalled: an item is held in the
// input register, and the compare/dwell logic plus the phase update resolve as
// it moves to the result register, where its result is then valid.
// A stalled result holds the result register; the input register still takes
// an item if it is empty and holds it until the result register frees.
// Reset (rst_n low, synchronous) restores register defaults and the xy phase.
// ----------------------------------------------------------------------------
module stable_stop_goal_checker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  ssgc_in_if.sink                           in_ch,
  ssgc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ssgc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ssgc_pkg::CfgW-1:0]         cfg_wdata
);
  import ssgc_pkg::*;

  // configuration
  logic [TolW-1:0]      x_tol_r, y_tol_r;
  logic [AngW-1:0]      yaw_tol_r;
  logic [2*StopW-1:0]   lim2_r;
  logic [StopW-1:0]     stop_turn_r;
  logic [TimeW-1:0]     xy_dwell_r, yaw_dwell_r;
  logic                 staged_r;

  // goal state
  logic                 checking_xy_r, checking_xy_nxt;
  logic                 xy_holding_r, xy_holding_nxt;
  logic                 yaw_holding_r, yaw_holding_nxt;
  logic [TimeW-1:0]     xy_start_r, xy_start_nxt;
  logic [TimeW-1:0]     yaw_start_r, yaw_start_nxt;

  // pipeline
  logic                 s1_valid_r;
  ssgc_in_t             s1_data_r;
  logic                 out_valid_r;
  ssgc_out_t            out_data_r, out_data_nxt;
  logic                 s1_adv;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_tol_r     <= TolW'(16384);
      y_tol_r     <= TolW'(16384);
      yaw_tol_r   <= AngW'(2608);
      lim2_r      <= (2*StopW)'(62500);
      stop_turn_r <= StopW'(250);
      xy_dwell_r  <= TimeW'(500);
      yaw_dwell_r <= TimeW'(500);
      staged_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (ssgc_reg_t'(cfg_index))
        REG_X_TOL:     x_tol_r     <= cfg_wdata[TolW-1:0];
        REG_Y_TOL:     y_tol_r     <= cfg_wdata[TolW-1:0];
        REG_YAW_TOL:   yaw_tol_r   <= cfg_wdata[AngW-1:0];
        // keep the squared limit, speed is compared as a squared magnitude
        REG_STOP_SPD:  lim2_r      <= (2*StopW)'(cfg_wdata[StopW-1:0]) *
                                      (2*StopW)'(cfg_wdata[StopW-1:0]);
        REG_STOP_TURN: stop_turn_r <= cfg_wdata[StopW-1:0];
        REG_XY_DWELL:  xy_dwell_r  <= cfg_wdata[TimeW-1:0];
        REG_YAW_DWELL: yaw_dwell_r <= cfg_wdata[TimeW-1:0];
        REG_STAGED:    staged_r    <= cfg_wdata[0];
      endcase
    end
  end

  // tolerance and stop checks on the registered item
  logic signed [PosW:0] diff_x, diff_y;
  logic [PosW-1:0]      dx, dy;
  logic [AngW-1:0]      yd, dyaw;
  logic [VelW-1:0]      ax, ay, at;
  logic [2*VelW-1:0]    sq_x, sq_y;
  logic [2*VelW:0]      spd2;
  logic                 xy_ok, yaw_ok, stopped;
  logic [TimeW-1:0]     xy_elapsed, yaw_elapsed;

  always_comb begin
    diff_x = {s1_data_r.query_x[PosW-1], s1_data_r.query_x}
           - {s1_data_r.goal_x[PosW-1], s1_data_r.goal_x};
    diff_y = {s1_data_r.query_y[PosW-1], s1_data_r.query_y}
           - {s1_data_r.goal_y[PosW-1], s1_data_r.goal_y};
    dx = diff_x[PosW] ? PosW'(-diff_x) : diff_x[PosW-1:0];
    dy = diff_y[PosW] ? PosW'(-diff_y) : diff_y[PosW-1:0];
    // wrapped difference; a half turn negates to itself
    yd   = s1_data_r.query_yaw - s1_data_r.goal_yaw;
    dyaw = yd[AngW-1] ? (~yd + AngW'(1)) : yd;

    ax = s1_data_r.vel_x[VelW-1]    ? VelW'(-s1_data_r.vel_x)    : s1_data_r.vel_x;
    ay = s1_data_r.vel_y[VelW-1]    ? VelW'(-s1_data_r.vel_y)    : s1_data_r.vel_y;
    at = s1_data_r.vel_turn[VelW-1] ? VelW'(-s1_data_r.vel_turn) : s1_data_r.vel_turn;
    sq_x = (2*VelW)'(ax) * (2*VelW)'(ax);
    sq_y = (2*VelW)'(ay) * (2*VelW)'(ay);
    spd2 = {1'b0, sq_x} + {1'b0, sq_y};

    xy_ok   = (dx <= PosW'(x_tol_r)) && (dy <= PosW'(y_tol_r));
    yaw_ok  = dyaw <= yaw_tol_r;
    stopped = (at <= VelW'(stop_turn_r)) && (spd2 <= (2*VelW+1)'(lim2_r));

    // a timer that starts on this item has zero elapsed time
    xy_elapsed  = xy_holding_r  ? (s1_data_r.time_ms - xy_start_r)  : '0;
    yaw_elapsed = yaw_holding_r ? (s1_data_r.time_ms - yaw_start_r) : '0;
  end

  // phase update and result
  always_comb begin
    checking_xy_nxt = checking_xy_r;
    xy_holding_nxt  = xy_holding_r;
    yaw_holding_nxt = yaw_holding_r;
    xy_start_nxt    = xy_holding_r  ? xy_start_r  : s1_data_r.time_ms;
    yaw_start_nxt   = yaw_start_r;
    out_data_nxt    = '0;

    priority if (s1_data_r.mode == MODE_RESTART) begin
      checking_xy_nxt = 1'b1;
      xy_holding_nxt  = 1'b0;
      yaw_holding_nxt = 1'b0;
      xy_start_nxt    = xy_start_r;
    end else if (staged_r && checking_xy_r) begin
      out_data_nxt.pose_ok = xy_ok;
      if (xy_ok) begin
        xy_holding_nxt = 1'b1;
        if (xy_elapsed >= xy_dwell_r) begin
          checking_xy_nxt = 1'b0;
          xy_holding_nxt  = 1'b0;
          yaw_holding_nxt = 1'b0;
        end
      end else begin
        xy_holding_nxt = 1'b0;
        xy_start_nxt   = xy_start_r;
      end
    end else if (staged_r) begin
      out_data_nxt.pose_ok = yaw_ok;
      xy_start_nxt = xy_start_r;
      if (yaw_ok) begin
        yaw_holding_nxt = 1'b1;
        yaw_start_nxt   = yaw_holding_r ? yaw_start_r : s1_data_r.time_ms;
        out_data_nxt.goal_reached = (yaw_elapsed >= yaw_dwell_r) && stopped;
      end else begin
        yaw_holding_nxt = 1'b0;
      end
    end else begin
      out_data_nxt.pose_ok = xy_ok && yaw_ok;
      if (xy_ok && yaw_ok) begin
        xy_holding_nxt = 1'b1;
        out_data_nxt.goal_reached = (xy_elapsed >= xy_dwell_r) && stopped;
      end else begin
        xy_holding_nxt = 1'b0;
        xy_start_nxt   = xy_start_r;
      end
    end

    if (s1_data_r.mode != MODE_RESTART) begin
      out_data_nxt.in_yaw_phase = staged_r && !checking_xy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      checking_xy_r <= 1'b1;
      xy_holding_r  <= 1'b0;
      yaw_holding_r <= 1'b0;
      xy_start_r    <= '0;
      yaw_start_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r   <= 1'b1;
        checking_xy_r <= checking_xy_nxt;
        xy_holding_r  <= xy_holding_nxt;
        yaw_holding_r <= yaw_holding_nxt;
        xy_start_r    <= xy_start_nxt;
        yaw_start_r   <= yaw_start_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // a restart item always yields an all-zero result
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_data_r.mode == MODE_RESTART) |=> out_valid_r && (out_data_r == '0))
    else $error("restart item gave a nonzero result");

  a_reached_pose: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.goal_reached |-> out_data_r.pose_ok)
    else $error("goal reached without pose in tolerance");

  a_yaw_staged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.in_yaw_phase |-> staged_r)
    else $error("yaw phase reported in combined mode");

  a_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(checking_xy_r) |-> !xy_holding_r && !yaw_holding_r)
    else $error("holding flags left set on entry to yaw phase");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("stalled item dropped from input register");

endmodule
